### design/dcqp_pkg.sv
// ---------------------------------------------------------------------------
// dcqp_pkg: shared types and constants of the DSI command queue packer
// DSI data type codes, header type codes, phase and status codes, and the
// result word that travels from the packer to the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

package dcqp_pkg;

    localparam int MAX_PAYLOAD_DEFAULT = 64;

    // input word layout
    localparam int S_DATA_W = 24;   // data_type, payload_count, payload_byte
    // output word layout
    localparam int M_DATA_W = 48;   // queue_word, word_index, queue_size, status, pad

    localparam int WORD_W   = 32;
    localparam int SLOT_W   = 5;
    localparam int STATUS_W = 3;
    localparam int PART_W   = 24;

    // queue header type field
    localparam logic [1:0] HDR_SHORT = 2'd0;
    localparam logic [1:0] HDR_LONG  = 2'd2;

    // packer phase
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SHORT = 2'd1;
    localparam logic [1:0] PH_LONG  = 2'd2;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_READ    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_STRAY   = 3'd4;

    // DSI write types
    localparam logic [7:0] DT_GEN_SHORT_WR0 = 8'h03;
    localparam logic [7:0] DT_GEN_SHORT_WR1 = 8'h13;
    localparam logic [7:0] DT_GEN_SHORT_WR2 = 8'h23;
    localparam logic [7:0] DT_DCS_SHORT_WR0 = 8'h05;
    localparam logic [7:0] DT_DCS_SHORT_WR1 = 8'h15;
    localparam logic [7:0] DT_GEN_LONG_WR   = 8'h29;
    localparam logic [7:0] DT_DCS_LONG_WR   = 8'h39;
    // DSI read types
    localparam logic [7:0] DT_GEN_RD0       = 8'h04;
    localparam logic [7:0] DT_GEN_RD1       = 8'h14;
    localparam logic [7:0] DT_GEN_RD2       = 8'h24;
    localparam logic [7:0] DT_DCS_RD        = 8'h06;

    typedef struct packed {
        logic is_write;
        logic is_read;
    } dtype_class_t;

    typedef struct packed {
        logic [WORD_W-1:0]   queue_word;
        logic [SLOT_W-1:0]   word_index;
        logic [SLOT_W-1:0]   queue_size;
        logic [STATUS_W-1:0] status;
        logic                last_word;
    } result_t;

endpackage

`default_nettype wire

### design/dcqp_type_decode.sv
// ---------------------------------------------------------------------------
// dcqp_type_decode: DSI data type classifier
// Sorts a data type code into write, read or neither.
// ---------------------------------------------------------------------------
`default_nettype none

module dcqp_type_decode
    import dcqp_pkg::*;
(
    input  wire logic [7:0]   data_type,
    output dtype_class_t      dt_class
);

    always_comb begin
        dt_class = '0;
        unique case (data_type) inside
            DT_GEN_SHORT_WR0, DT_GEN_SHORT_WR1, DT_GEN_SHORT_WR2,
            DT_DCS_SHORT_WR0, DT_DCS_SHORT_WR1,
            DT_GEN_LONG_WR, DT_DCS_LONG_WR: begin
                dt_class.is_write = 1'b1;
            end
            DT_GEN_RD0, DT_GEN_RD1, DT_GEN_RD2, DT_DCS_RD: begin
                dt_class.is_read = 1'b1;
            end
            default: begin
                dt_class = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/dcqp_packer.sv
// ---------------------------------------------------------------------------
// dcqp_packer: command state and queue word builder
// Tracks the command in flight and forms at most one result per word.
// ---------------------------------------------------------------------------
`default_nettype none

module dcqp_packer
    import dcqp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         accept,
    input  wire logic         command,
    input  wire logic [7:0]   data_type,
    input  wire logic [7:0]   payload_count,
    input  wire logic [7:0]   payload_byte,
    input  wire dtype_class_t dt_class,
    output logic              res_valid,
    output result_t           res
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    logic [1:0]        phase_reg,    phase_next;
    logic [7:0]        kind_reg,     kind_next;
    logic [CNT_W-1:0]  expected_reg, expected_next;
    logic [CNT_W-1:0]  received_reg, received_next;
    logic [PART_W-1:0] partial_reg,  partial_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;

    logic [CNT_W-1:0]  received_inc;
    logic              done;
    logic [1:0]        pos;
    logic [WORD_W-1:0] long_word;
    logic [15:0]       short_data;

    assign received_inc = received_reg + CNT_W'(1);
    assign done         = received_inc >= expected_reg;
    assign pos          = received_reg[1:0];

    always_comb begin
        long_word = {8'h00, partial_reg};
        case (pos)
            2'd0:    long_word[7:0]   = payload_byte;
            2'd1:    long_word[15:8]  = payload_byte;
            2'd2:    long_word[23:16] = payload_byte;
            default: long_word[31:24] = payload_byte;
        endcase
    end

    always_comb begin
        short_data = partial_reg[15:0];
        if (received_reg[0]) begin
            short_data[15:8] = payload_byte;
        end else begin
            short_data[7:0] = payload_byte;
        end
    end

    always_comb begin
        phase_next    = phase_reg;
        kind_next     = kind_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        partial_next  = partial_reg;
        slot_next     = slot_reg;
        res_valid     = 1'b0;
        res           = '0;
        res.status    = ST_OK;

        if (accept) begin
            if (!command) begin
                phase_next    = PH_IDLE;
                received_next = '0;
                partial_next  = '0;
                slot_next     = '0;
                if (!dt_class.is_write) begin
                    res_valid     = 1'b1;
                    res.status    = dt_class.is_read ? ST_READ : ST_INVALID;
                    res.last_word = 1'b1;
                end else if ({1'b0, payload_count} > 9'(MAX_PAYLOAD)) begin
                    res_valid     = 1'b1;
                    res.status    = ST_RANGE;
                    res.last_word = 1'b1;
                end else begin
                    kind_next     = data_type;
                    expected_next = CNT_W'(payload_count);
                    if (payload_count > 8'd2) begin
                        phase_next     = PH_LONG;
                        slot_next      = SLOT_W'(1);
                        res_valid      = 1'b1;
                        res.queue_word = {8'h00, payload_count, data_type, 6'd0, HDR_LONG};
                    end else if (payload_count == 8'd0) begin
                        res_valid      = 1'b1;
                        res.queue_word = {16'h0000, data_type, 6'd0, HDR_SHORT};
                        res.queue_size = SLOT_W'(1);
                        res.last_word  = 1'b1;
                    end else begin
                        phase_next = PH_SHORT;
                    end
                end
            end else begin
                unique case (phase_reg)
                    PH_SHORT: begin
                        received_next = received_inc;
                        partial_next  = {8'h00, short_data};
                        if (done) begin
                            phase_next     = PH_IDLE;
                            partial_next   = '0;
                            received_next  = '0;
                            res_valid      = 1'b1;
                            res.queue_word = {short_data, kind_reg, 6'd0, HDR_SHORT};
                            res.queue_size = SLOT_W'(1);
                            res.last_word  = 1'b1;
                        end
                    end
                    PH_LONG: begin
                        received_next = received_inc;
                        if (pos == 2'd3 || done) begin
                            partial_next   = '0;
                            slot_next      = slot_reg + SLOT_W'(1);
                            res_valid      = 1'b1;
                            res.queue_word = long_word;
                            res.word_index = slot_reg;
                            if (done) begin
                                phase_next     = PH_IDLE;
                                received_next  = '0;
                                res.queue_size = slot_reg + SLOT_W'(1);
                                res.last_word  = 1'b1;
                            end
                        end else begin
                            partial_next = long_word[PART_W-1:0];
                        end
                    end
                    default: begin
                        res_valid     = 1'b1;
                        res.status    = ST_STRAY;
                        res.last_word = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            kind_reg     <= '0;
            expected_reg <= '0;
            received_reg <= '0;
            partial_reg  <= '0;
            slot_reg     <= '0;
        end else begin
            phase_reg    <= phase_next;
            kind_reg     <= kind_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            partial_reg  <= partial_next;
            slot_reg     <= slot_next;
        end
    end

`ifndef ASSERT_OFF
    // byte count is cleared whenever no command is being collected
    a_idle_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> received_reg == '0)
        else $error("byte count left over in idle phase");
    // a short command never gathers more than two bytes
    a_short_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SHORT |-> received_reg < expected_reg && expected_reg <= CNT_W'(2))
        else $error("short command count out of bounds");
`endif

endmodule

`default_nettype wire

### design/dcqp_out_stage.sv
// ---------------------------------------------------------------------------
// dcqp_out_stage: result register
// Holds one result word until the receiver takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module dcqp_out_stage
    import dcqp_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     res_valid,
    input  wire result_t  res,
    output logic          room,
    output logic          out_valid,
    output result_t       out_res,
    input  wire logic     out_ready
);

    logic    valid_reg;
    result_t res_reg;

    assign room      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_valid) begin
            valid_reg <= 1'b1;
        end else if (out_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

### design/dsi_command_queue_packer.sv
// ---------------------------------------------------------------------------
// dsi_command_queue_packer: DSI write command to command-queue word packer
// Takes a command header word followed by its payload byte words and
// produces the 32-bit words of a display controller command queue.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (s_): one word per handshake. s_tuser = 0 marks a command
//   header (data_type, payload_count), s_tuser = 1 one payload byte.
//   Output channel (m_): queue words with slot, queue size and status;
//   m_tlast marks the final word of a command and every error word.
//   A header of 0..2 bytes yields one short header, at once for 0 bytes, else after its last byte;
//   longer writes yield a long header at once, then one word per four bytes.
//   A result is registered and appears on m_ in the cycle after the word that causes it.
//   Throughput: one input word per cycle while m_ is not stalled, set by the
//   single result register; the packer state updates in the same cycle it takes a word.
//   Reset (aresetn low, synchronous) returns the packer to idle and drops
//   any pending result.
//   When the receiver stalls with a result held, s_tready drops until that
//   result is taken; words that produce no result still need the slot free.
// ---------------------------------------------------------------------------
`default_nettype none

module dsi_command_queue_packer
    import dcqp_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // input channel
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // [7:0] data_type, [15:8] payload_count,
                                                // [23:16] payload_byte
    input  wire logic                s_tuser,   // [0] command: 0 header, 1 payload byte
    // result channel
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,   // [31:0] queue_word, [36:32] word_index,
                                                // [41:37] queue_size, [44:42] status,
                                                // [47:45] zero
    output logic                     m_tlast    // last_word
);

    logic         accept;
    logic         room;
    logic         res_valid;
    result_t      res;
    result_t      out_res;
    dtype_class_t dt_class;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    dcqp_type_decode u_type_decode (
        .data_type (s_tdata[7:0]),
        .dt_class  (dt_class)
    );

    dcqp_packer #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_packer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (accept),
        .command       (s_tuser),
        .data_type     (s_tdata[7:0]),
        .payload_count (s_tdata[15:8]),
        .payload_byte  (s_tdata[23:16]),
        .dt_class      (dt_class),
        .res_valid     (res_valid),
        .res           (res)
    );

    dcqp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .room      (room),
        .out_valid (m_tvalid),
        .out_res   (out_res),
        .out_ready (m_tready)
    );

    assign m_tdata = {3'b000, out_res.status, out_res.queue_size,
                      out_res.word_index, out_res.queue_word};
    assign m_tlast = out_res.last_word;

`ifndef ASSERT_OFF
    // error words carry no queue content and always close the command
    a_error_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res.status != ST_OK |->
            m_tlast && out_res.queue_word == '0 && out_res.queue_size == '0)
        else $error("error result with payload or without last");
    // queue size is reported only on the final word of a good command
    a_size_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && out_res.queue_size != '0 |-> m_tlast && out_res.status == ST_OK)
        else $error("queue size on a non-final word");
    // a word is never taken while a held result is stalled
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("input taken over a stalled result");
`endif

endmodule

`default_nettype wire

### verif/dsi_command_queue_packer_test.sv
// ---------------------------------------------------------------------------
// dsi_command_queue_packer_test: self-checking bench for the queue packer
// Walks a short table of directed header and payload words, then random
// command sequences, mostly well-formed writes with some noise. Every
// accepted input word steps a local packer model, and every result word on
// the master side is checked field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module dsi_command_queue_packer_test;
    import dcqp_pkg::*;

    localparam int MAX_LEN      = MAX_PAYLOAD_DEFAULT;
    localparam int N_DIRECTED   = 25;
    localparam int N_RANDOM     = 500;
    localparam int QUIET_AFTER  = N_DIRECTED + 420;  // no idling past this word
    localparam int HOLD_AFTER   = N_DIRECTED + 150;  // long receiver hold-off here
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 20;

    localparam logic [7:0] WRITE_TYPES [7] = '{DT_GEN_SHORT_WR0, DT_GEN_SHORT_WR1,
        DT_GEN_SHORT_WR2, DT_DCS_SHORT_WR0, DT_DCS_SHORT_WR1, DT_GEN_LONG_WR,
        DT_DCS_LONG_WR};
    localparam logic [7:0] READ_TYPES [4] = '{DT_GEN_RD0, DT_GEN_RD1, DT_GEN_RD2,
        DT_DCS_RD};

    // one directed stimulus row; want is used only where has_fixed is set
    typedef struct {
        logic       cmd;
        logic [7:0] dt;
        logic [7:0] cnt;
        logic [7:0] pb;
        bit         has_fixed;
        result_t    want;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;    // [7:0] data_type, [15:8] payload_count,
                                     // [23:16] payload_byte
    logic                s_tuser;    // [0] command: 0 header, 1 payload byte
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;    // [31:0] queue_word, [36:32] word_index,
                                     // [41:37] queue_size, [44:42] status, [47:45] zero
    logic                m_tlast;    // last_word

    dsi_command_queue_packer #(
        .MAX_PAYLOAD(MAX_LEN)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    // packer model state
    logic [1:0]  mdl_phase;
    logic [7:0]  mdl_kind;
    int          mdl_len;
    int          mdl_rcvd;
    logic [23:0] mdl_part;
    logic [7:0]  mdl_slot;

    result_t     pending_words[$];   // predicted queue words, oldest first
    stim_row_t   directed[N_DIRECTED];

    int unsigned words_sent;
    int unsigned words_checked;
    int unsigned error_count;
    int unsigned cycle_count;
    bit          quiet;              // no idling on either side
    bit          hold_req;           // sender asks the receiver for a long hold-off
    bit          hold_given;         // the long hold-off has been requested

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_words.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Packer model: one accepted input word in, at most one queue word out.
    task automatic pack_step(input logic cmd, input logic [7:0] dt, input logic [7:0] cnt,
                             input logic [7:0] pb, output bit has_word, output result_t w);
        int          pos;
        bit          done;
        logic [31:0] word;
        w = '0;
        w.last_word = 1'b1;
        has_word = 1'b1;
        if (!cmd) begin
            // header: any unfinished command is dropped
            mdl_phase = PH_IDLE;
            mdl_rcvd  = 0;
            mdl_part  = '0;
            mdl_slot  = '0;
            if (!(dt inside {WRITE_TYPES})) begin
                w.status = (dt inside {READ_TYPES}) ? ST_READ : ST_INVALID;
            end else if (cnt > MAX_LEN) begin
                w.status = ST_RANGE;
            end else begin
                mdl_kind = dt;
                mdl_len  = cnt;
                if (cnt > 2) begin
                    // long header goes out at once, payload from slot 1
                    mdl_phase    = PH_LONG;
                    mdl_slot     = 8'd1;
                    w.queue_word = {8'h00, cnt, dt, 6'd0, HDR_LONG};
                    w.last_word  = 1'b0;
                end else if (cnt == 0) begin
                    w.queue_word = {16'h0000, dt, 6'd0, HDR_SHORT};
                    w.queue_size = 5'd1;
                end else begin
                    mdl_phase = PH_SHORT;
                    has_word  = 1'b0;
                end
            end
        end else if (mdl_phase == PH_SHORT) begin
            mdl_part = mdl_part | (24'(pb) << (8 * (mdl_rcvd % 2)));
            mdl_rcvd++;
            if (mdl_rcvd >= mdl_len) begin
                w.queue_word = {mdl_part[15:0], mdl_kind, 6'd0, HDR_SHORT};
                w.queue_size = 5'd1;
                mdl_phase    = PH_IDLE;
                mdl_part     = '0;
                mdl_rcvd     = 0;
            end else begin
                has_word = 1'b0;
            end
        end else if (mdl_phase == PH_LONG) begin
            pos  = mdl_rcvd % 4;
            word = {8'h00, mdl_part} | (32'(pb) << (8 * pos));
            mdl_rcvd++;
            done = (mdl_rcvd >= mdl_len);
            if (pos == 3 || done) begin
                w.queue_word = word;
                w.word_index = mdl_slot[4:0];
                mdl_part     = '0;
                if (done) begin
                    w.queue_size = 5'(mdl_slot + 8'd1);
                    mdl_phase    = PH_IDLE;
                    mdl_rcvd     = 0;
                end else begin
                    w.last_word = 1'b0;
                end
                mdl_slot = mdl_slot + 8'd1;
            end else begin
                mdl_part = word[23:0];
                has_word = 1'b0;
            end
        end else begin
            // payload byte with no command open
            w.status = ST_STRAY;
        end
    endtask

    // Offer one word at the falling edge, hold it until taken, then predict.
    task automatic apply_word(input stim_row_t row);
        bit      has_word;
        result_t w;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge aclk);
        end
        s_tuser  = row.cmd;
        s_tdata  = {row.pb, row.cnt, row.dt};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        pack_step(row.cmd, row.dt, row.cnt, row.pb, has_word, w);
        if (row.has_fixed) begin
            pending_words.push_back(row.want);
        end else if (has_word) begin
            pending_words.push_back(w);
        end
    endtask

    task automatic send_header(input logic [7:0] dt, input logic [7:0] cnt);
        stim_row_t row;
        row = '{1'b0, dt, cnt, 8'($urandom), 1'b0, '0};
        apply_word(row);
    endtask

    task automatic send_bytes(input int n);
        stim_row_t row;
        repeat (n) begin
            row = '{1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0};
            apply_word(row);
        end
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[31:0], m_tdata[36:32], m_tdata[41:37], m_tdata[44:42], m_tlast};
            if (pending_words.size() == 0) begin
                $error("unexpected queue word %h (slot %0d, status %0d)",
                       got.queue_word, got.word_index, got.status);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                words_checked++;
                if (got.queue_word !== want.queue_word) begin
                    $error("queue_word: expected %h, got %h", want.queue_word, got.queue_word);
                    error_count++;
                end
                if (got.word_index !== want.word_index) begin
                    $error("word_index: expected %0d, got %0d", want.word_index,
                           got.word_index);
                    error_count++;
                end
                if (got.queue_size !== want.queue_size) begin
                    $error("queue_size: expected %0d, got %0d", want.queue_size,
                           got.queue_size);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.last_word !== want.last_word) begin
                    $error("last_word: expected %0d, got %0d", want.last_word, got.last_word);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int         roll;
        int         len;
        int         nbytes;
        int         drain;
        logic [7:0] dt;

        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        hold_given = 1'b0;
        mdl_phase  = PH_IDLE;
        mdl_kind   = '0;
        mdl_len    = 0;
        mdl_rcvd   = 0;
        mdl_part   = '0;
        mdl_slot   = '0;

        // directed rows: errors and short/long edges typed in, the rest predicted
        directed = '{
            // stray byte right after reset
            '{1'b1, 8'h00, 8'h00, 8'hFF, 1'b1, '{32'd0, 5'd0, 5'd0, ST_STRAY, 1'b1}},
            // read types
            '{1'b0, DT_GEN_RD0, 8'h00, 8'h00, 1'b1, '{32'd0, 5'd0, 5'd0, ST_READ, 1'b1}},
            '{1'b0, DT_GEN_RD2, 8'hFF, 8'hFF, 1'b1, '{32'd0, 5'd0, 5'd0, ST_READ, 1'b1}},
            // invalid types, all ones and all zeros
            '{1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b1, '{32'd0, 5'd0, 5'd0, ST_INVALID, 1'b1}},
            '{1'b0, 8'h00, 8'h01, 8'h00, 1'b1, '{32'd0, 5'd0, 5'd0, ST_INVALID, 1'b1}},
            // byte after a rejected header is stray
            '{1'b1, 8'hFF, 8'hFF, 8'h00, 1'b1, '{32'd0, 5'd0, 5'd0, ST_STRAY, 1'b1}},
            // zero-length write: short header at once
            '{1'b0, DT_DCS_SHORT_WR0, 8'h00, 8'hFF, 1'b1,
              '{{16'h0000, DT_DCS_SHORT_WR0, 6'd0, HDR_SHORT}, 5'd0, 5'd1, ST_OK, 1'b1}},
            // one past max length, and max count
            '{1'b0, DT_GEN_LONG_WR, 8'(MAX_LEN + 1), 8'h00, 1'b1,
              '{32'd0, 5'd0, 5'd0, ST_RANGE, 1'b1}},
            '{1'b0, DT_DCS_LONG_WR, 8'hFF, 8'h00, 1'b1, '{32'd0, 5'd0, 5'd0, ST_RANGE, 1'b1}},
            // max-length long header, then dropped by the next header
            '{1'b0, DT_GEN_LONG_WR, 8'(MAX_LEN), 8'h00, 1'b1,
              '{{8'h00, 8'(MAX_LEN), DT_GEN_LONG_WR, 6'd0, HDR_LONG}, 5'd0, 5'd0,
                ST_OK, 1'b0}},
            // two-byte short write
            '{1'b0, DT_DCS_SHORT_WR1, 8'h02, 8'h00, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'hAB, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'hCD, 1'b0, '0},
            // one-byte short write
            '{1'b0, DT_GEN_SHORT_WR1, 8'h01, 8'h00, 1'b0, '0},
            '{1'b1, 8'hFF, 8'hFF, 8'h00, 1'b0, '0},
            // short write cut off by a three-byte long write
            '{1'b0, DT_GEN_SHORT_WR2, 8'h02, 8'h00, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'h11, 1'b0, '0},
            '{1'b0, DT_DCS_LONG_WR, 8'h03, 8'h00, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'h01, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'h02, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'h03, 1'b0, '0},
            // four-byte write given three bytes: long header only, the write left open
            '{1'b0, DT_GEN_SHORT_WR0, 8'h04, 8'h00, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'hFF, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'hFF, 1'b0, '0},
            '{1'b1, 8'h00, 8'h00, 8'hFF, 1'b0, '0}
        };

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed[i]) apply_word(directed[i]);

        // random commands, mostly well-formed writes
        while (words_sent < N_DIRECTED + N_RANDOM) begin
            roll = $urandom_range(0, 99);
            if (roll < 75) begin
                dt   = WRITE_TYPES[$urandom_range(0, 6)];
                roll = $urandom_range(0, 19);
                if (roll == 0) len = MAX_LEN;
                else if (roll < 4) len = $urandom_range(3, MAX_LEN);
                else len = $urandom_range(0, 12);
                nbytes = len;
                roll = $urandom_range(0, 19);
                if (roll == 0 && len > 0) nbytes = $urandom_range(0, len - 1);  // cut short
                else if (roll == 1) nbytes = len + 1;                           // one too many
                send_header(dt, 8'(len));
                send_bytes(nbytes);
            end else if (roll < 83) begin
                send_header(READ_TYPES[$urandom_range(0, 3)], 8'($urandom));
                send_bytes($urandom_range(0, 2));
            end else if (roll < 90) begin
                do dt = 8'($urandom); while (dt inside {WRITE_TYPES, READ_TYPES});
                send_header(dt, 8'($urandom));
            end else if (roll < 95) begin
                send_header(WRITE_TYPES[$urandom_range(0, 6)],
                            8'($urandom_range(MAX_LEN + 1, 255)));
            end else begin
                send_bytes($urandom_range(1, 3));
            end
            // one long hold-off once the run is well under way
            if (words_sent >= HOLD_AFTER && !hold_given) begin
                hold_given = 1'b1;
                hold_req   = 1'b1;
            end
            if (words_sent >= QUIET_AFTER) quiet = 1'b1;
        end

        @(negedge aclk);
        s_tvalid = 1'b0;

        drain = 0;
        while (pending_words.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pending_words.size() != 0) begin
            $error("%0d queue words expected but never seen", pending_words.size());
            error_count++;
        end

        $display("Run: %0d input words, %0d queue words checked, %0d mismatches",
                 words_sent, words_checked, error_count);
        $display("Covered errors, stray bytes, short and long writes up to max length");
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
